[hdl/sat_pkg.sv]
// Shared types, field widths and codes for the sorted arrival table.
package sat_pkg;

  localparam int CAPACITY    = 256;
  localparam int DAY_SECONDS = 86400;
  localparam int TAG_BITS    = 16;

  localparam int TIME_W   = 18;
  localparam int SEQ_W    = 16;
  localparam int TAG_W    = 16;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int FUNC_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Result gathering: cells are ORed in registered groups, then the groups.
  localparam int GROUP_SIZE = 16;
  localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int SLOTS      = GROUPS * GROUP_SIZE;

  localparam logic [TAG_W-1:0] TAG_MASK =
    (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_v;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } hit_t;

  // Broadcast to every cell; ins_en is set only in the cycle an insert is accepted and the table is not full.
  typedef struct packed {
    logic ins_en;
    logic search;
    logic read;
  } cell_ctl_t;

endpackage

[hdl/sat_if.sv]
// Valid/ready channel interfaces for request and result items.
interface sat_in_if;
  logic                       valid;
  logic                       ready;
  logic [sat_pkg::FUNC_W-1:0] func;
  logic [sat_pkg::TIME_W-1:0] time_value;
  logic [sat_pkg::SEQ_W-1:0]  stop_seq;
  logic [sat_pkg::TAG_W-1:0]  trip_tag;
  logic [sat_pkg::IDX_W-1:0]  entry_index;

  modport source (output valid, func, time_value, stop_seq, trip_tag, entry_index,
                  input ready);
  modport sink   (input valid, func, time_value, stop_seq, trip_tag, entry_index,
                  output ready);
endinterface

interface sat_out_if;
  logic                         valid;
  logic                         ready;
  logic [sat_pkg::STATUS_W-1:0] status;
  logic [sat_pkg::IDX_W-1:0]    found_index;
  logic [sat_pkg::TIME_W-1:0]   found_time;
  logic [sat_pkg::SEQ_W-1:0]    found_stop_seq;
  logic [sat_pkg::TAG_W-1:0]    found_trip_tag;
  logic [sat_pkg::CNT_W-1:0]    count_now;
  logic [sat_pkg::TIME_W-1:0]   overage_now;

  modport source (output valid, status, found_index, found_time, found_stop_seq,
                  found_trip_tag, count_now, overage_now,
                  input ready);
  modport sink   (input valid, status, found_index, found_time, found_stop_seq,
                  found_trip_tag, count_now, overage_now,
                  output ready);
endinterface

[hdl/sat_cell.sv]
// One table slot: holds an entry, compares it to the query, shifts or loads on insert.
module sat_cell (
  input  logic                       clk,
  input  sat_pkg::cell_ctl_t         ctl,
  input  sat_pkg::entry_t            new_entry,
  input  logic [sat_pkg::TIME_W-1:0] query,
  input  logic                       is_first,
  input  logic                       valid_self,
  input  logic                       left_valid,
  input  logic                       left_le,
  input  sat_pkg::entry_t            left_entry,
  input  logic                       right_le,
  input  logic                       idx_match,
  input  logic [sat_pkg::IDX_W-1:0]  cell_index,
  output logic                       le,
  output sat_pkg::entry_t            entry_out,
  output sat_pkg::hit_t              hit
);

  sat_pkg::entry_t entry_r;
  logic            shift_in;
  logic            take_new;
  logic            sel;

  assign le = valid_self && (entry_r.time_v <= query);

  // Later entries move up one slot; the first slot past the last early entry loads.
  assign shift_in = ctl.ins_en && left_valid && !left_le;
  assign take_new = ctl.ins_en && (is_first || left_le) && !le;

  always_ff @(posedge clk) begin
    if (shift_in) begin
      entry_r <= left_entry;
    end else if (take_new) begin
      entry_r <= new_entry;
    end
  end

  // Search hit is the last slot at or before the query.
  assign sel = take_new
            || (ctl.search && le && !right_le)
            || (ctl.read && idx_match && valid_self);

  assign entry_out = entry_r;
  assign hit       = sel ? {cell_index, entry_r} : '0;

endmodule

[hdl/sat_group.sv]
// Registered OR of the hit words from one group of cells.
module sat_group (
  input  logic                                   clk,
  input  logic                                   en,
  input  sat_pkg::hit_t [sat_pkg::GROUP_SIZE-1:0] hits,
  output sat_pkg::hit_t                          hit_r
);

  sat_pkg::hit_t hit_nxt;

  always_comb begin
    hit_nxt = '0;
    for (int k = 0; k < sat_pkg::GROUP_SIZE; k++) begin
      hit_nxt = hit_nxt | hits[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

[hdl/sorted_arrival_table.sv]
// Sorted arrival table: a row of cells, one per slot, keeps entries ordered by time.
// An insert, search or read is decided by all cells at once in the cycle the item is
// accepted (an insert shifts later entries up in that same edge). The selected cell's
// entry is then collected through a two-level registered OR tree: the group registers
// load on the accepting edge and the result register on the next one. The result is
// valid once the result register loads; no new item is accepted while one is in the
// gather stage or while a held result waits for the output to be ready. Equal times
// keep arrival order: inserts go after them and a search returns the last of them.
module sorted_arrival_table (
  input  logic      clk,
  input  logic      rst_n,
  sat_in_if.sink    in_if,
  sat_out_if.source out_if
);

  localparam int CAP = sat_pkg::CAPACITY;

  logic                         in_acc;
  sat_pkg::func_t               func;
  sat_pkg::cell_ctl_t           ctl;
  sat_pkg::entry_t              new_entry;
  logic                         full;
  logic                         out_of_range;

  logic [sat_pkg::CNT_W-1:0]    count_r,   count_nxt;
  logic [sat_pkg::TIME_W-1:0]   overage_r, overage_nxt;

  logic                         a_valid_r;
  sat_pkg::func_t               a_func_r;
  sat_pkg::status_t             a_status_r;
  sat_pkg::entry_t              a_new_r;
  sat_pkg::status_t             status_now;

  logic                         out_valid_r;
  sat_pkg::status_t             out_status_r;
  sat_pkg::hit_t                out_hit_r;
  sat_pkg::hit_t                out_hit_nxt;
  sat_pkg::hit_t                tree_hit;

  logic            [CAP-1:0]    valid;
  logic            [CAP-1:0]    le;
  sat_pkg::entry_t [CAP-1:0]    entries;
  sat_pkg::hit_t   [sat_pkg::SLOTS-1:0]  hits;
  sat_pkg::hit_t   [sat_pkg::GROUPS-1:0] grp_hit;

  assign in_if.ready = !a_valid_r && (!out_valid_r || out_if.ready);
  assign in_acc      = in_if.valid && in_if.ready;
  assign func        = sat_pkg::func_t'(in_if.func);

  assign new_entry.time_v = in_if.time_value;
  assign new_entry.seq    = in_if.stop_seq;
  assign new_entry.tag    = in_if.trip_tag & sat_pkg::TAG_MASK;

  assign full         = (count_r == sat_pkg::CNT_W'(CAP));
  assign out_of_range = (32'(in_if.entry_index) >= 32'(count_r));

  assign ctl.ins_en = in_acc && (func == sat_pkg::FUNC_INSERT) && !full;
  assign ctl.search = (func == sat_pkg::FUNC_SEARCH);
  assign ctl.read   = (func == sat_pkg::FUNC_READ);

  // ---- cell row ----
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic            left_valid;
    logic            left_le;
    sat_pkg::entry_t left_entry;
    logic            right_le;

    assign valid[i] = (sat_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_valid = 1'b0;
      assign left_le    = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_valid = valid[i-1];
      assign left_le    = le[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_le = 1'b0;
    end else begin : g_inner
      assign right_le = le[i+1];
    end

    sat_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .query      (in_if.time_value),
      .is_first   (i == 0),
      .valid_self (valid[i]),
      .left_valid (left_valid),
      .left_le    (left_le),
      .left_entry (left_entry),
      .right_le   (right_le),
      .idx_match  (32'(in_if.entry_index) == i),
      .cell_index (sat_pkg::IDX_W'(i)),
      .le         (le[i]),
      .entry_out  (entries[i]),
      .hit        (hits[i])
    );
  end

  for (genvar j = CAP; j < sat_pkg::SLOTS; j++) begin : g_pad
    assign hits[j] = '0;
  end

  // ---- first tree level ----
  for (genvar g = 0; g < sat_pkg::GROUPS; g++) begin : g_grp
    sat_group u_group (
      .clk   (clk),
      .en    (in_acc),
      .hits  (hits[g*sat_pkg::GROUP_SIZE +: sat_pkg::GROUP_SIZE]),
      .hit_r (grp_hit[g])
    );
  end

  // ---- status and state update at acceptance ----
  always_comb begin
    unique case (func)
      sat_pkg::FUNC_INSERT: status_now = full ? sat_pkg::ST_FULL : sat_pkg::ST_OK;
      sat_pkg::FUNC_SEARCH: status_now = le[0] ? sat_pkg::ST_OK : sat_pkg::ST_NONE;
      sat_pkg::FUNC_READ:   status_now = out_of_range ? sat_pkg::ST_RANGE : sat_pkg::ST_OK;
      default:              status_now = sat_pkg::ST_OK;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    overage_nxt = overage_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + sat_pkg::CNT_W'(1);
      if ({1'b0, in_if.time_value} >
          (19'(sat_pkg::DAY_SECONDS) + {1'b0, overage_r})) begin
        overage_nxt = sat_pkg::TIME_W'(in_if.time_value - sat_pkg::TIME_W'(sat_pkg::DAY_SECONDS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      overage_r <= '0;
      a_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      overage_r <= overage_nxt;
      a_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_func_r   <= func;
      a_status_r <= status_now;
      a_new_r    <= new_entry;
    end
  end

  // ---- second tree level and result register ----
  always_comb begin
    tree_hit = '0;
    for (int g = 0; g < sat_pkg::GROUPS; g++) begin
      tree_hit = tree_hit | grp_hit[g];
    end
  end

  always_comb begin
    out_hit_nxt = '0;
    if (a_status_r == sat_pkg::ST_OK && a_func_r != sat_pkg::FUNC_NONE) begin
      out_hit_nxt.idx   = tree_hit.idx;
      // An insert reports the item itself; the row has already taken it.
      out_hit_nxt.entry = (a_func_r == sat_pkg::FUNC_INSERT) ? a_new_r : tree_hit.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      out_status_r <= a_status_r;
      out_hit_r    <= out_hit_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.found_index    = out_hit_r.idx;
  assign out_if.found_time     = out_hit_r.entry.time_v;
  assign out_if.found_stop_seq = out_hit_r.entry.seq;
  assign out_if.found_trip_tag = out_hit_r.entry.tag;
  assign out_if.count_now      = count_r;
  assign out_if.overage_now    = overage_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sat_pkg::CNT_W'(CAP))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == sat_pkg::FUNC_INSERT && !full)
      |=> count_r == $past(count_r) + sat_pkg::CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> !out_valid_r)
    else $error("gather stage would overwrite a pending result");

  a_search_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == sat_pkg::FUNC_SEARCH && !le[0]) |=> a_status_r == sat_pkg::ST_NONE)
    else $error("search with no earlier entry not flagged");

endmodule
